@@ src/tatb_pkg.sv @@
`default_nettype none

package tatb_pkg;

  // Coordinate and coefficient formats.
  localparam int COORD_BITS = 32;                    // signed Q16.16
  localparam int COEFF_BITS = 16;                    // signed Q4.12
  localparam int FRAC_BITS  = COEFF_BITS - 4;
  localparam int ROW_BITS   = 3 * COEFF_BITS;

  // Internal arithmetic widths.
  localparam int PROD_BITS = COORD_BITS + COEFF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int FLR_BITS  = SUM_BITS - FRAC_BITS;
  localparam int TOT_BITS  = FLR_BITS + 1;

  // Stream and configuration port widths.
  localparam int S_DATA_BITS = 3 * COORD_BITS;
  localparam int M_DATA_BITS = 9 * COORD_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (ROW_BITS > COORD_BITS) ? ROW_BITS : COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEFF_BITS-1:0] coeff_t;
  typedef logic        [ROW_BITS-1:0]   row_t;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT_Z = 3'd5;

  // Identity matrix: 1.0 on the diagonal.
  localparam row_t ROW_X_RESET = row_t'(1) << FRAC_BITS;
  localparam row_t ROW_Y_RESET = row_t'(1) << (FRAC_BITS + COEFF_BITS);
  localparam row_t ROW_Z_RESET = row_t'(1) << (FRAC_BITS + 2 * COEFF_BITS);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Control between the top level and the row datapaths.
  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } tatb_adv_t;

  // Clamp a wide signed value to the coordinate range.
  function automatic coord_t sat_coord(input logic signed [TOT_BITS-1:0] v);
    logic [TOT_BITS-COORD_BITS:0] hi;
    hi = v[TOT_BITS-1:COORD_BITS-1];
    if ((&hi) || (~|hi)) begin
      return coord_t'(v[COORD_BITS-1:0]);
    end else if (v[TOT_BITS-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

`default_nettype wire

@@ src/tatb_row.sv @@
`default_nettype none

// One output row: three products, then floor, translate and saturate.
module tatb_row import tatb_pkg::*; (
  input  wire logic      clk,
  input  wire tatb_adv_t adv,
  input  wire row_t      coeffs,
  input  wire coord_t    shift,
  input  wire coord_t    vert_x,
  input  wire coord_t    vert_y,
  input  wire coord_t    vert_z,
  output coord_t         res
);

  coeff_t k_x, k_y, k_z;
  logic signed [PROD_BITS-1:0] prod_x, prod_y, prod_z;
  logic signed [SUM_BITS-1:0]  sum;
  logic signed [FLR_BITS-1:0]  flr;
  logic signed [TOT_BITS-1:0]  tot;

  assign k_x = coeffs[COEFF_BITS-1:0];
  assign k_y = coeffs[2*COEFF_BITS-1:COEFF_BITS];
  assign k_z = coeffs[3*COEFF_BITS-1:2*COEFF_BITS];

  always_ff @(posedge clk) begin
    if (adv.ld_prod) begin
      prod_x <= vert_x * k_x;
      prod_y <= vert_y * k_y;
      prod_z <= vert_z * k_z;
    end
  end

  // The arithmetic shift of the full sum rounds toward minus infinity.
  always_comb begin
    sum = SUM_BITS'(prod_x) + SUM_BITS'(prod_y) + SUM_BITS'(prod_z);
    flr = sum[SUM_BITS-1:FRAC_BITS];
    tot = TOT_BITS'(flr) + TOT_BITS'(shift);
  end

  always_ff @(posedge clk) begin
    if (adv.ld_sum) begin
      res <= sat_coord(tot);
    end
  end

endmodule

`default_nettype wire

@@ src/triangle_affine_transform_bounds.sv @@
`default_nettype none

// Channel  Handshake                  Payload
// -------  -------------------------  ------------------------------------------
// s        s_tvalid / s_tready        s_tdata: vert_x, vert_y, vert_z
// m        m_tvalid / m_tready        m_tdata: out xyz, box min xyz, box max xyz
//                                     m_tlast: tri_done
// cfg      cfg_valid / cfg_ready      cfg_index, cfg_data (always ready)
//
// One vertex is accepted per cycle while s_tready is high. Its result is
// offered on m after it passes the registers in order: the input register loads
// at the edge that accepted it, then the product register, the saturated sum
// register and the output register follow.
// Reset clears the stage valid flags and the vertex phase, and sets the
// configuration registers to an identity transform. A stall on m only holds the
// stages that are full, so empty stages behind it keep taking vertices.
module triangle_affine_transform_bounds import tatb_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Vertex stream.
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [S_DATA_BITS-1:0]   s_tdata,   // vert_x, vert_y, vert_z
  // Result stream.
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // out_x, out_y, out_z, box_min_x, box_min_y, box_min_z,
  // box_max_x, box_max_y, box_max_z
  output logic [M_DATA_BITS-1:0]        m_tdata,
  output logic                          m_tlast,   // tri_done
  // Register writes.
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_THIRD = 2'd2;

  // Configuration registers.
  row_t   row_x, row_y, row_z;
  coord_t shift_x, shift_y, shift_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x   <= ROW_X_RESET;
      row_y   <= ROW_Y_RESET;
      row_z   <= ROW_Z_RESET;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_X:   row_x   <= cfg_data[ROW_BITS-1:0];
        REG_ROW_Y:   row_y   <= cfg_data[ROW_BITS-1:0];
        REG_ROW_Z:   row_z   <= cfg_data[ROW_BITS-1:0];
        REG_SHIFT_X: shift_x <= cfg_data[COORD_BITS-1:0];
        REG_SHIFT_Y: shift_y <= cfg_data[COORD_BITS-1:0];
        REG_SHIFT_Z: shift_z <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control. Each stage loads when it is empty or its
  // contents move on in the same cycle.
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  tatb_adv_t adv;
  logic ld4;

  assign rdy4 = !m_tvalid || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_tready = rdy1;

  assign adv.ld_prod = v1 && rdy2;
  assign adv.ld_sum  = v2 && rdy3;
  assign ld4         = v3 && rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) m_tvalid <= v3;
    end
  end

  // Input register.
  coord_t in_x, in_y, in_z;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_x <= s_tdata[COORD_BITS-1:0];
      in_y <= s_tdata[2*COORD_BITS-1:COORD_BITS];
      in_z <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    end
  end

  coord_t res [3];

  tatb_row u_row_x (
    .clk(clk), .adv(adv), .coeffs(row_x), .shift(shift_x),
    .vert_x(in_x), .vert_y(in_y), .vert_z(in_z), .res(res[0])
  );

  tatb_row u_row_y (
    .clk(clk), .adv(adv), .coeffs(row_y), .shift(shift_y),
    .vert_x(in_x), .vert_y(in_y), .vert_z(in_z), .res(res[1])
  );

  tatb_row u_row_z (
    .clk(clk), .adv(adv), .coeffs(row_z), .shift(shift_z),
    .vert_x(in_x), .vert_y(in_y), .vert_z(in_z), .res(res[2])
  );

  // Triangle bounds. The first vertex of a triangle overwrites the running
  // extremes; the third one reports them and wraps the phase.
  logic [1:0] phase;
  coord_t run_min [3];
  coord_t run_max [3];
  coord_t min_next [3];
  coord_t max_next [3];
  logic   done;

  assign done = (phase == PH_THIRD);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (phase == PH_FIRST) begin
        min_next[i] = res[i];
        max_next[i] = res[i];
      end else begin
        min_next[i] = (res[i] < run_min[i]) ? res[i] : run_min[i];
        max_next[i] = (res[i] > run_max[i]) ? res[i] : run_max[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
    end else if (ld4) begin
      phase <= done ? PH_FIRST : phase + 2'd1;
    end
  end

  coord_t out_pt [3];
  coord_t box_min [3];
  coord_t box_max [3];

  always_ff @(posedge clk) begin
    if (ld4) begin
      m_tlast <= done;
      for (int i = 0; i < 3; i++) begin
        run_min[i] <= min_next[i];
        run_max[i] <= max_next[i];
        out_pt[i]  <= res[i];
        box_min[i] <= done ? min_next[i] : '0;
        box_max[i] <= done ? max_next[i] : '0;
      end
    end
  end

  assign m_tdata = {box_max[2], box_max[1], box_max[0],
                    box_min[2], box_min[1], box_min[0],
                    out_pt[2],  out_pt[1],  out_pt[0]};

endmodule

`default_nettype wire

@@ src/tatb_checker.sv @@
`default_nettype none

module tatb_checker import tatb_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [M_DATA_BITS-1:0] m_tdata,
  input wire logic                   m_tlast
);

  localparam int CB = COORD_BITS;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Bounds are zero on the first two vertices of a triangle.
  a_box_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tdata[M_DATA_BITS-1:3*CB] == '0))
    else $error("bounds not zero before the third vertex");

  // The reported box is ordered and holds the last vertex.
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      ($signed(m_tdata[4*CB-1:3*CB]) <= $signed(m_tdata[CB-1:0])) &&
      ($signed(m_tdata[CB-1:0])      <= $signed(m_tdata[7*CB-1:6*CB])) &&
      ($signed(m_tdata[5*CB-1:4*CB]) <= $signed(m_tdata[2*CB-1:CB])) &&
      ($signed(m_tdata[2*CB-1:CB])   <= $signed(m_tdata[8*CB-1:7*CB])) &&
      ($signed(m_tdata[6*CB-1:5*CB]) <= $signed(m_tdata[3*CB-1:2*CB])) &&
      ($signed(m_tdata[3*CB-1:2*CB]) <= $signed(m_tdata[9*CB-1:8*CB])))
    else $error("bounding box does not enclose the vertex");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind triangle_affine_transform_bounds tatb_checker u_tatb_checker (.*);

`default_nettype wire
